>>> src/kss_pkg.sv
// ----------------------------------------------------------------------------
// kss_pkg
// Types, codes and helpers shared by the keyboard serial sender.
// ----------------------------------------------------------------------------
package kss_pkg;

	localparam int unsigned BITS_PER_FRAME = 8;
	localparam int unsigned PERIOD_W = 24;

	typedef enum logic [2:0] {
		PH_SET_DAT  = 3'd0,
		PH_CLK_LOW  = 3'd1,
		PH_CLK_HIGH = 3'd2,
		PH_END      = 3'd3,
		PH_WAIT     = 3'd4,
		PH_BEGIN    = 3'd5,
		PH_IDLE     = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_ACK  = 2'd1,
		CMD_SEND = 2'd2
	} cmd_t;

	localparam logic [1:0] FAIL_OK       = 2'd0;
	localparam logic [1:0] FAIL_PENDING  = 2'd1;
	localparam logic [1:0] FAIL_LOST     = 2'd2;

	localparam logic [1:0] SYNC_NONE     = 2'd0;
	localparam logic [1:0] SYNC_INIT     = 2'd1;
	localparam logic [1:0] SYNC_TERM     = 2'd2;

	localparam logic [0:0] CFG_FRAME_PERIOD  = 1'd0;
	localparam logic [0:0] CFG_RESYNC_PERIOD = 1'd1;

	localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RST  = 24'd385;
	localparam logic [PERIOD_W-1:0] RESYNC_PERIOD_RST = 24'd2288064;

	localparam logic [7:0] CODE_LOST_SYNC   = 8'hF9;
	localparam logic [7:0] CODE_INIT_STREAM = 8'hFD;
	localparam logic [7:0] CODE_TERM_STREAM = 8'hFE;

	typedef struct packed {
		logic [1:0] recovering;
		logic [1:0] link_sync;
		logic       is_idle;
		logic       accepted;
		logic       drive_lines;
		logic       dat_out;
		logic       clk_out;
	} result_t;

	function automatic logic [7:0] rot_inv(input logic [7:0] v);
		rot_inv = ~{v[6:0], v[7]};
	endfunction

endpackage

>>> src/keyboard_serial_sender_with_resync.sv
// ----------------------------------------------------------------------------
// keyboard_serial_sender_with_resync
// Keyboard-side serial frame sender with power-up stream and resync recovery.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_*      | in        | tuser = cmd, tdata = keycode
//  m_*      | out       | tdata = line levels and status, one per input transaction
//  cfg_*    | in        | frame_period (index 0), resync_period (index 1)
//
//  One input transaction per cycle unless the output stalls; its result is formed from
//  the input register and held in the output register until m_* takes it.
//  The state update is one pass of logic between the input and output registers.
//  Reset starts a one-bit frame with the frame timer running.
//  A stalled output holds the pipeline; s_tready drops only when both stages are full.
module keyboard_serial_sender_with_resync
	import kss_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,  // [7:0] keycode
	input  logic [1:0]          s_tuser,  // [1:0] cmd
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata,  // [0] clk_out, [1] dat_out, [2] drive_lines,
	                                      // [3] accepted, [4] is_idle, [6:5] link_sync,
	                                      // [8:7] recovering, [15:9] zero
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [PERIOD_W-1:0] cfg_data
);

	logic                valid_s1;
	logic [1:0]          cmd_s1;
	logic [7:0]          keycode_s1;
	logic                valid_s2;
	result_t             result_s2;
	result_t             result;
	logic                advance;
	logic [PERIOD_W-1:0] frame_period_q;
	logic [PERIOD_W-1:0] resync_period_q;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, result_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_period_q  <= FRAME_PERIOD_RST;
			resync_period_q <= RESYNC_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_PERIOD:  frame_period_q  <= cfg_data;
				CFG_RESYNC_PERIOD: resync_period_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (m_tready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1     <= s_tuser;
			keycode_s1 <= s_tdata;
		end
		if (advance)
			result_s2 <= result;
	end

	kss_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.cmd           (cmd_s1),
		.keycode       (keycode_s1),
		.frame_period  (frame_period_q),
		.resync_period (resync_period_q),
		.result        (result)
	);

endmodule

>>> src/kss_core.sv
// ----------------------------------------------------------------------------
// kss_core
// Sender state, frame/resync timer and the per-transaction state update.
// ----------------------------------------------------------------------------
module kss_core
	import kss_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [1:0]          cmd,
	input  logic [7:0]          keycode,
	input  logic [PERIOD_W-1:0] frame_period,
	input  logic [PERIOD_W-1:0] resync_period,
	output result_t             result
);

	phase_t              phase_q, phase_n;
	logic [3:0]          bit_index_q, bit_index_n;
	logic [7:0]          shift_byte_q, shift_byte_n;
	logic [7:0]          saved_byte_q, saved_byte_n;
	logic [1:0]          fail_mode_q, fail_mode_n;
	logic [1:0]          sync_mode_q, sync_mode_n;
	logic [PERIOD_W-1:0] tick_count_q, tick_count_n;
	logic                long_timeout_q, long_timeout_n;
	logic                timer_running_q, timer_running_n;
	logic                ack_armed_q, ack_armed_n;
	logic                clk_level_q, clk_level_n;
	logic                dat_level_q, dat_level_n;
	logic                lines_driven_q, lines_driven_n;

	logic [PERIOD_W-1:0] period;
	logic [PERIOD_W-1:0] tick_next;
	logic [3:0]          bit_inc;
	logic                acc;
	logic                load;

	assign period    = long_timeout_q ? resync_period : frame_period;
	assign tick_next = tick_count_q + 1'b1;
	assign bit_inc   = bit_index_q + 1'b1;

	always_comb begin
		phase_n         = phase_q;
		bit_index_n     = bit_index_q;
		shift_byte_n    = shift_byte_q;
		saved_byte_n    = saved_byte_q;
		fail_mode_n     = fail_mode_q;
		sync_mode_n     = sync_mode_q;
		tick_count_n    = tick_count_q;
		long_timeout_n  = long_timeout_q;
		timer_running_n = timer_running_q;
		ack_armed_n     = ack_armed_q;
		clk_level_n     = clk_level_q;
		dat_level_n     = dat_level_q;
		lines_driven_n  = lines_driven_q;
		acc             = 1'b0;
		load            = 1'b0;

		case (cmd)
			CMD_TICK: begin
				if (timer_running_q) begin
					if (tick_next >= period || tick_next == '0) begin
						tick_count_n = '0;
						case (phase_q)
							PH_BEGIN: begin
								bit_index_n    = '0;
								fail_mode_n    = FAIL_OK;
								lines_driven_n = 1'b1;
								phase_n        = PH_SET_DAT;
							end
							PH_SET_DAT: begin
								dat_level_n = bit_index_q[3] ? 1'b0
									: shift_byte_q[3'd7 - bit_index_q[2:0]];
								phase_n = PH_CLK_LOW;
							end
							PH_CLK_LOW: begin
								clk_level_n = 1'b0;
								phase_n     = PH_CLK_HIGH;
							end
							PH_CLK_HIGH: begin
								clk_level_n = 1'b1;
								bit_index_n = bit_inc;
								phase_n     = (32'(bit_inc) < BITS_PER_FRAME) ? PH_SET_DAT
									: PH_END;
							end
							PH_END: begin
								lines_driven_n  = 1'b0;
								clk_level_n     = 1'b1;
								dat_level_n     = 1'b1;
								phase_n         = PH_WAIT;
								long_timeout_n  = 1'b1;
								timer_running_n = 1'b1;
								ack_armed_n     = 1'b1;
							end
							PH_WAIT: begin
								// resync: one-bit frame, save the pending code once
								ack_armed_n = 1'b0;
								if (sync_mode_q != SYNC_NONE && fail_mode_q == FAIL_OK) begin
									fail_mode_n  = FAIL_PENDING;
									saved_byte_n = shift_byte_q;
								end
								bit_index_n     = 4'd7;
								shift_byte_n    = '0;
								phase_n         = PH_SET_DAT;
								long_timeout_n  = 1'b0;
								timer_running_n = 1'b1;
								lines_driven_n  = 1'b1;
							end
							default: begin
							end
						endcase
					end else begin
						tick_count_n = tick_next;
					end
				end
			end
			CMD_ACK: begin
				if (ack_armed_q) begin
					ack_armed_n     = 1'b0;
					timer_running_n = 1'b0;
					if (phase_q == PH_WAIT) begin
						load = 1'b1;
						if (fail_mode_q != FAIL_OK) begin
							if (fail_mode_q == FAIL_PENDING) begin
								bit_index_n  = '0;
								shift_byte_n = rot_inv(CODE_LOST_SYNC);
								fail_mode_n  = FAIL_LOST;
								phase_n      = PH_SET_DAT;
							end else if (fail_mode_q == FAIL_LOST) begin
								bit_index_n  = '0;
								shift_byte_n = saved_byte_q;
								fail_mode_n  = FAIL_OK;
								phase_n      = PH_SET_DAT;
							end
						end else if (sync_mode_q == SYNC_TERM) begin
							phase_n = PH_IDLE;
							load    = 1'b0;
						end else if (sync_mode_q == SYNC_NONE) begin
							bit_index_n  = '0;
							shift_byte_n = rot_inv(CODE_INIT_STREAM);
							sync_mode_n  = SYNC_INIT;
							phase_n      = PH_SET_DAT;
						end else if (sync_mode_q == SYNC_INIT) begin
							bit_index_n  = '0;
							shift_byte_n = rot_inv(CODE_TERM_STREAM);
							sync_mode_n  = SYNC_TERM;
							phase_n      = PH_SET_DAT;
						end
						if (load) begin
							long_timeout_n  = 1'b0;
							tick_count_n    = '0;
							timer_running_n = 1'b1;
							lines_driven_n  = 1'b1;
						end
					end
				end
			end
			CMD_SEND: begin
				if (phase_q == PH_IDLE) begin
					shift_byte_n    = rot_inv(keycode);
					phase_n         = PH_BEGIN;
					long_timeout_n  = 1'b0;
					tick_count_n    = '0;
					timer_running_n = 1'b1;
					acc             = 1'b1;
				end
			end
			default: begin
			end
		endcase

		result.clk_out     = clk_level_n;
		result.dat_out     = dat_level_n;
		result.drive_lines = lines_driven_n;
		result.accepted    = acc;
		result.is_idle     = (phase_n == PH_IDLE);
		result.link_sync   = sync_mode_n;
		result.recovering  = fail_mode_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_SET_DAT;
			bit_index_q     <= 4'd7;
			shift_byte_q    <= '0;
			saved_byte_q    <= '0;
			fail_mode_q     <= FAIL_OK;
			sync_mode_q     <= SYNC_NONE;
			tick_count_q    <= '0;
			long_timeout_q  <= 1'b0;
			timer_running_q <= 1'b1;
			ack_armed_q     <= 1'b0;
			clk_level_q     <= 1'b1;
			dat_level_q     <= 1'b1;
			lines_driven_q  <= 1'b1;
		end else if (step) begin
			phase_q         <= phase_n;
			bit_index_q     <= bit_index_n;
			shift_byte_q    <= shift_byte_n;
			saved_byte_q    <= saved_byte_n;
			fail_mode_q     <= fail_mode_n;
			sync_mode_q     <= sync_mode_n;
			tick_count_q    <= tick_count_n;
			long_timeout_q  <= long_timeout_n;
			timer_running_q <= timer_running_n;
			ack_armed_q     <= ack_armed_n;
			clk_level_q     <= clk_level_n;
			dat_level_q     <= dat_level_n;
			lines_driven_q  <= lines_driven_n;
		end
	end

endmodule

>>> src/kss_checker.sv
// ----------------------------------------------------------------------------
// kss_checker
// Port-level checks for the keyboard serial sender, bound to the top level.
// ----------------------------------------------------------------------------
module kss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// released lines read back at the pull-up level
	a_released_high: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tdata[0] && m_tdata[1])
		else $error("released lines not high");

	// a taken keycode leaves the sender busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> !m_tdata[4])
		else $error("accepted transaction while still idle");

	// idle only after the power-up stream finished and no recovery pending
	a_idle_synced: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tdata[6:5] == 2'd2 && m_tdata[8:7] == 2'd0)
		else $error("idle while unsynced or recovering");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transaction changed while stalled");

endmodule

bind keyboard_serial_sender_with_resync kss_checker u_kss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> tb/kss_link_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kss_link_checker
// Watches the input, output and configuration ports of the serial sender,
// predicts the line levels and link status for every input transaction and
// compares each output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module kss_link_checker
	import kss_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [7:0]          s_tdata,  // [7:0] keycode
	input  logic [1:0]          s_tuser,  // [1:0] cmd
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [15:0]         m_tdata,  // [0] clk_out, [1] dat_out, [2] drive_lines,
	                                      // [3] accepted, [4] is_idle, [6:5] link_sync,
	                                      // [8:7] recovering, [15:9] zero
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [PERIOD_W-1:0] cfg_data,
	output int                  fail_count,
	output int                  pending,
	output logic                awaiting_ack,
	output logic                link_idle,
	output int                  checked,
	output int                  keys_taken,
	output int                  resync_bits
);

	// predicted sender state
	logic [PERIOD_W-1:0] frame_len, resync_len;
	phase_t              frame_ph;
	logic [3:0]          bit_idx;
	logic [7:0]          shreg, saved_code;
	logic [1:0]          fail_st, sync_st;
	logic [PERIOD_W-1:0] tmr_cnt;
	logic                tmr_long, tmr_on, armed;
	logic                clk_lvl, dat_lvl, driven;

	result_t line_q[$];
	result_t next_lines, want, got;

	function automatic logic [7:0] invert_rotl(input logic [7:0] v);
		return ~((v << 1) | (v >> 7));
	endfunction

	task automatic arm_timer(input logic use_long);
		tmr_long = use_long;
		tmr_cnt = '0;
		tmr_on = 1'b1;
	endtask

	task automatic step_link(input logic [1:0] c, input logic [7:0] key, output result_t r);
		logic [PERIOD_W-1:0] limit, nxt;
		logic took, load;
		took = 1'b0;
		case (c)
		CMD_TICK: begin
			if (tmr_on) begin
				limit = tmr_long ? resync_len : frame_len;
				nxt = tmr_cnt + 1'b1;
				if (nxt >= limit || nxt == '0) begin
					tmr_cnt = '0;
					case (frame_ph)
					PH_BEGIN: begin
						bit_idx = '0;
						fail_st = FAIL_OK;
						driven = 1'b1;
						frame_ph = PH_SET_DAT;
					end
					PH_SET_DAT: begin
						dat_lvl = (bit_idx < BITS_PER_FRAME) ? shreg[4'd7 - bit_idx] : 1'b0;
						frame_ph = PH_CLK_LOW;
					end
					PH_CLK_LOW: begin
						clk_lvl = 1'b0;
						frame_ph = PH_CLK_HIGH;
					end
					PH_CLK_HIGH: begin
						clk_lvl = 1'b1;
						bit_idx = bit_idx + 1'b1;
						frame_ph = (bit_idx < BITS_PER_FRAME) ? PH_SET_DAT : PH_END;
					end
					PH_END: begin
						driven = 1'b0;
						clk_lvl = 1'b1;
						dat_lvl = 1'b1;
						frame_ph = PH_WAIT;
						arm_timer(1'b1);
						armed = 1'b1;
					end
					PH_WAIT: begin
						// no ack in time: one-bit resync frame
						armed = 1'b0;
						if (sync_st != SYNC_NONE && fail_st == FAIL_OK) begin
							fail_st = FAIL_PENDING;
							saved_code = shreg;
						end
						bit_idx = 4'd7;
						shreg = '0;
						frame_ph = PH_SET_DAT;
						arm_timer(1'b0);
						driven = 1'b1;
						resync_bits++;
					end
					default: ;
					endcase
				end else begin
					tmr_cnt = nxt;
				end
			end
		end
		CMD_ACK: begin
			if (armed) begin
				armed = 1'b0;
				tmr_on = 1'b0;
				if (frame_ph == PH_WAIT) begin
					if (fail_st == FAIL_OK && sync_st == SYNC_TERM) begin
						frame_ph = PH_IDLE;
					end else begin
						load = 1'b1;
						if (fail_st == FAIL_PENDING) begin
							shreg = invert_rotl(CODE_LOST_SYNC);
							fail_st = FAIL_LOST;
						end else if (fail_st == FAIL_LOST) begin
							shreg = saved_code;
							fail_st = FAIL_OK;
						end else if (fail_st == FAIL_OK && sync_st == SYNC_NONE) begin
							shreg = invert_rotl(CODE_INIT_STREAM);
							sync_st = SYNC_INIT;
						end else if (fail_st == FAIL_OK && sync_st == SYNC_INIT) begin
							shreg = invert_rotl(CODE_TERM_STREAM);
							sync_st = SYNC_TERM;
						end else begin
							load = 1'b0;
						end
						if (load) begin
							bit_idx = '0;
							frame_ph = PH_SET_DAT;
						end
						arm_timer(1'b0);
						driven = 1'b1;
					end
				end
			end
		end
		CMD_SEND: begin
			if (frame_ph == PH_IDLE) begin
				shreg = invert_rotl(key);
				frame_ph = PH_BEGIN;
				arm_timer(1'b0);
				took = 1'b1;
				keys_taken++;
			end
		end
		default: ;
		endcase
		r.clk_out = clk_lvl;
		r.dat_out = dat_lvl;
		r.drive_lines = driven;
		r.accepted = took;
		r.is_idle = (frame_ph == PH_IDLE);
		r.link_sync = sync_st;
		r.recovering = fail_st;
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len = FRAME_PERIOD_RST;
			resync_len = RESYNC_PERIOD_RST;
			frame_ph = PH_SET_DAT;
			bit_idx = 4'd7;
			shreg = '0;
			saved_code = '0;
			fail_st = FAIL_OK;
			sync_st = SYNC_NONE;
			tmr_cnt = '0;
			tmr_long = 1'b0;
			tmr_on = 1'b1;
			armed = 1'b0;
			clk_lvl = 1'b1;
			dat_lvl = 1'b1;
			driven = 1'b1;
			line_q.delete();
			fail_count = 0;
			checked = 0;
			keys_taken = 0;
			resync_bits = 0;
			pending <= 0;
			awaiting_ack <= 1'b0;
			link_idle <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				CFG_FRAME_PERIOD:  frame_len = cfg_data;
				CFG_RESYNC_PERIOD: resync_len = cfg_data;
				default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				step_link(s_tuser, s_tdata, next_lines);
				line_q.push_back(next_lines);
			end
			if (m_tvalid && m_tready) begin
				if (line_q.size() == 0) begin
					$error("output transaction %h with nothing expected", m_tdata);
					fail_count++;
				end else begin
					want = line_q.pop_front();
					got = result_t'(m_tdata[8:0]);
					checked++;
					check_field("clk_out", 16'(want.clk_out), 16'(got.clk_out));
					check_field("dat_out", 16'(want.dat_out), 16'(got.dat_out));
					check_field("drive_lines", 16'(want.drive_lines),
						16'(got.drive_lines));
					check_field("accepted", 16'(want.accepted), 16'(got.accepted));
					check_field("is_idle", 16'(want.is_idle), 16'(got.is_idle));
					check_field("link_sync", 16'(want.link_sync), 16'(got.link_sync));
					check_field("recovering", 16'(want.recovering), 16'(got.recovering));
					check_field("tdata pad", 16'd0, 16'(m_tdata[15:9]));
				end
			end
			pending <= line_q.size();
			awaiting_ack <= armed;
			link_idle <= (frame_ph == PH_IDLE);
		end
	end

endmodule

>>> tb/keyboard_serial_sender_with_resync_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyboard_serial_sender_with_resync_tb
// Drives ticks, acknowledges and keycodes into the serial sender under a
// series of frame and resync period settings, with random idle cycles on
// both stream sides; the link checker predicts and compares every result.
// ----------------------------------------------------------------------------
module keyboard_serial_sender_with_resync_tb;
	import kss_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid, s_tready;
	logic [7:0]          s_tdata;
	logic [1:0]          s_tuser;
	logic                m_tvalid, m_tready;
	logic [15:0]         m_tdata;
	logic                cfg_we;
	logic [0:0]          cfg_index;
	logic [PERIOD_W-1:0] cfg_data;

	int   fail_count, pending, checked, keys_taken, resync_bits;
	logic awaiting_ack, link_idle;
	int   idle_max = 0;
	int   items_sent = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	keyboard_serial_sender_with_resync uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	kss_link_checker link_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending),
		.awaiting_ack(awaiting_ack), .link_idle(link_idle),
		.checked(checked), .keys_taken(keys_taken), .resync_bits(resync_bits)
	);

	task automatic send_item(input logic [1:0] c, input logic [7:0] k);
		int gap;
		gap = $urandom_range(0, idle_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c;
		s_tdata <= k;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// wait until every result is back, then idle for pipeline slack
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_periods(input logic [PERIOD_W-1:0] frame_p,
		input logic [PERIOD_W-1:0] resync_p);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FRAME_PERIOD;
		cfg_data <= frame_p;
		@(posedge clk);
		cfg_index <= CFG_RESYNC_PERIOD;
		cfg_data <= resync_p;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// host side: ack when the frame is done, send keys when idle, plus noise
	task automatic host_item();
		int r;
		logic [1:0] c;
		logic [7:0] k;
		r = $urandom_range(0, 99);
		k = 8'($urandom);
		if (r < 10)
			c = 2'($urandom_range(0, 3));
		else if (link_idle)
			c = (r < 75) ? CMD_SEND : CMD_TICK;
		else if (awaiting_ack)
			c = (r < 25) ? CMD_ACK : CMD_TICK;
		else
			c = CMD_TICK;
		if (c == CMD_SEND && r[0])
			k = r[1] ? 8'hFF : 8'h00;
		send_item(c, k);
	endtask

	task automatic run_phase(input logic [PERIOD_W-1:0] frame_p,
		input logic [PERIOD_W-1:0] resync_p, input int n, input int idle);
		settle();
		idle_max = idle;
		program_periods(frame_p, resync_p);
		repeat (n) host_item();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_TICK;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_FRAME_PERIOD;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unused cmd, busy send, stray ack, lowered and zero period
		idle_max = 3;
		program_periods(24'd5, 24'hFFFFFF);
		send_item(CMD_UNUSED, 8'hFF);
		send_item(CMD_SEND, 8'h00);
		send_item(CMD_ACK, 8'h5A);
		repeat (3) send_item(CMD_TICK, 8'hFF);
		settle();
		program_periods(24'd2, 24'hFFFFFF);
		send_item(CMD_TICK, 8'h00);
		settle();
		program_periods(24'd0, 24'hFFFFFF);
		repeat (3) send_item(CMD_TICK, 8'h00);
		send_item(CMD_ACK, 8'h00);
		send_item(CMD_SEND, 8'hFF);

		run_phase(24'd1, 24'd20, 260, 9);
		run_phase(24'd0, 24'd3, 200, 0);
		run_phase(24'd2, 24'd1, 150, 9);
		run_phase(24'd1, 24'd0, 100, 5);
		run_phase(24'hFFFFFF, 24'hFFFFFF, 40, 9);
		run_phase(24'($urandom_range(1, 3)), 24'($urandom_range(4, 60)), 300, 9);
		run_phase(24'd1, 24'd12, 300, 2);
		run_phase(24'd0, 24'd8, 300, 0);
		settle();

		$display("ran %0d input transactions across 11 period settings, %0d results checked",
			items_sent, checked);
		$display("keycodes taken: %0d, resync bits sent: %0d", keys_taken, resync_bits);
		if (fail_count == 0)
			$display("keyboard_serial_sender_with_resync: match");
		else
			$display("keyboard_serial_sender_with_resync: mismatch");
		$finish;
	end

	initial begin
		int w;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			w = $urandom_range(0, idle_max);
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		#5_000_000;
		$display("keyboard_serial_sender_with_resync: mismatch");
		$finish;
	end

endmodule
